// ===== rtl/core/wfg_pkg.sv =====
// ----------------------------------------------------------------------------
// wfg_pkg
// Types and codes shared by the wait-for graph deadlock detector.
// ----------------------------------------------------------------------------
package wfg_pkg;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_DETECT = 2'd3
	} act_t;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_REJ  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		act_t        action;
		logic [4:0]  slot;
		logic [63:0] txn_ts;
		logic [30:0] op_id;
		logic        has_waiter;
		logic [4:0]  waiter_slot;
		logic [63:0] waiter_ts;
		logic [30:0] waiter_op;
		logic        abort_flag;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic       deadlock;
	} rsp_t;

	typedef struct packed {
		logic [4:0]  slot;
		logic [63:0] ts;
		logic [30:0] op;
	} waiter_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_R_RD,
		ST_R_CMP,
		ST_S_RD,
		ST_S_WR,
		ST_W_POP,
		ST_W_CUR0,
		ST_W_CUR1,
		ST_W_ERD,
		ST_W_ESL,
		ST_W_ECHK
	} state_t;

endpackage

// ===== rtl/core/wfg_ram.sv =====
// ----------------------------------------------------------------------------
// wfg_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module wfg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/wfg_ctrl.sv =====
// ----------------------------------------------------------------------------
// wfg_ctrl
// Sequencer: group checks, list append, remove scan and shift, graph walk.
// ----------------------------------------------------------------------------
module wfg_ctrl #(
	parameter int SLOTS            = 32,
	parameter int WAITERS_PER_SLOT = 32
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            start,
	input  wfg_pkg::cmd_t                                   cmd,
	output logic                                            busy,
	output logic                                            done,
	output wfg_pkg::rsp_t                                   rsp,
	output logic                                            slot_we,
	output logic [$clog2(SLOTS)-1:0]                        slot_waddr,
	output logic [96+$clog2(WAITERS_PER_SLOT+1)-1:0]        slot_wdata,
	output logic [$clog2(SLOTS)-1:0]                        slot_raddr,
	input  logic [96+$clog2(WAITERS_PER_SLOT+1)-1:0]        slot_rdata,
	output logic                                            list_we,
	output logic [$clog2(SLOTS*WAITERS_PER_SLOT)-1:0]       list_waddr,
	output wfg_pkg::waiter_t                                list_wdata,
	output logic [$clog2(SLOTS*WAITERS_PER_SLOT)-1:0]       list_raddr,
	input  wfg_pkg::waiter_t                                list_rdata
);
	import wfg_pkg::*;

	localparam int AW  = $clog2(SLOTS);
	localparam int CW  = $clog2(WAITERS_PER_SLOT + 1);
	localparam int LAW = $clog2(SLOTS * WAITERS_PER_SLOT);
	localparam int QW  = $clog2(SLOTS + 1);
	localparam logic [8:0]    SLOT_LIM = 9'(SLOTS);
	localparam logic [CW-1:0] WPS_C    = CW'(WAITERS_PER_SLOT);
	localparam logic [QW-1:0] QCAP     = QW'(SLOTS);

	function automatic logic [LAW-1:0] laddr(input logic [AW-1:0] s, input logic [CW-1:0] i);
		laddr = LAW'(s) * LAW'(WAITERS_PER_SLOT) + LAW'(i);
	endfunction

	state_t          state_q, state_d;
	cmd_t            cmd_q;
	logic [63:0]     e_ts_q;
	logic [30:0]     e_op_q;
	logic            e_ab_q;
	logic [CW-1:0]   idx_q, n_q;
	logic [AW-1:0]   cur_q, w_q;
	logic [63:0]     wts_q;
	logic [SLOTS-1:0] vis_q, add_q, svld_q;
	logic            srd_vld_q;
	logic [QW-1:0]   rdp_q, wrp_q;
	logic            grp_open_q, grp_acc_q;
	logic            done_q;
	rsp_t            rsp_q;

	logic [63:0]     rd_ts;
	logic [30:0]     rd_op;
	logic            rd_ab;
	logic [CW-1:0]   rd_cnt;
	logic [AW-1:0]   s_idx;
	logic            s_ok, newer, same, bump, acc, full, ts_eq, w_ok;
	logic [63:0]     base_ts;
	logic [30:0]     base_op;
	logic            base_ab;
	logic [CW-1:0]   base_cnt, idx_nx;
	logic            fin, fin_dl;
	logic [1:0]      fin_st;
	logic            q_we;
	logic [AW-1:0]   q_waddr, q_wdata, q_raddr, q_rdata;

	wfg_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	assign rd_ts  = srd_vld_q ? slot_rdata[95+CW -: 64] : '0;
	assign rd_op  = srd_vld_q ? slot_rdata[31+CW -: 31] : '0;
	assign rd_ab  = srd_vld_q ? slot_rdata[CW] : 1'b0;
	assign rd_cnt = srd_vld_q ? slot_rdata[CW-1:0] : '0;

	assign s_idx  = AW'(cmd_q.slot);
	assign s_ok   = {4'b0, cmd_q.slot} < SLOT_LIM;
	assign newer  = rd_ts < cmd_q.txn_ts;
	assign same   = (rd_ts == cmd_q.txn_ts) && !rd_ab && (rd_op <= cmd_q.op_id);
	assign bump   = rd_op < cmd_q.op_id;
	assign acc    = grp_open_q ? grp_acc_q : (newer || same);
	assign ts_eq  = rd_ts == cmd_q.txn_ts;
	assign idx_nx = idx_q + CW'(1);
	assign w_ok   = {4'b0, list_rdata.slot} < SLOT_LIM;

	always_comb begin
		base_ts  = rd_ts;
		base_op  = rd_op;
		base_ab  = rd_ab;
		base_cnt = rd_cnt;
		if (!grp_open_q && newer) begin
			base_ts  = cmd_q.txn_ts;
			base_ab  = 1'b0;
		end
		if (!grp_open_q && (newer || (same && bump))) begin
			base_op  = cmd_q.op_id;
			base_cnt = '0;
		end
		full = base_cnt >= WPS_C;
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_st     = STAT_OK;
		fin_dl     = 1'b0;
		slot_raddr = AW'(cmd.slot);
		slot_we    = 1'b0;
		slot_waddr = s_idx;
		slot_wdata = {e_ts_q, e_op_q, e_ab_q, n_q - CW'(1)};
		list_raddr = laddr(s_idx, idx_q);
		list_we    = 1'b0;
		list_waddr = laddr(s_idx, idx_q);
		list_wdata = list_rdata;
		q_we       = 1'b0;
		q_waddr    = AW'(wrp_q);
		q_wdata    = w_q;
		q_raddr    = AW'(rdp_q);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = ST_IDLE;
				if (!s_ok) begin
					fin    = 1'b1;
					fin_st = STAT_REJ;
				end else if (cmd_q.action == ACT_ADD) begin
					fin        = 1'b1;
					slot_we    = acc;
					slot_wdata = {base_ts, base_op, base_ab, base_cnt};
					list_waddr = laddr(s_idx, base_cnt);
					list_wdata = '{slot: cmd_q.waiter_slot, ts: cmd_q.waiter_ts,
						op: cmd_q.waiter_op};
					if (!acc) begin
						fin_st = STAT_REJ;
					end else if (cmd_q.has_waiter) begin
						if (full) begin
							fin_st = STAT_FULL;
						end else begin
							list_we    = 1'b1;
							slot_wdata = {base_ts, base_op, base_ab, base_cnt + CW'(1)};
						end
					end
				end else if (!ts_eq) begin
					fin    = 1'b1;
					fin_st = STAT_REJ;
				end else begin
					case (cmd_q.action)
						ACT_REMOVE: begin
							if (cmd_q.has_waiter) begin
								state_d = ST_R_RD;
							end else begin
								fin = 1'b1;
							end
						end
						ACT_CLEAR: begin
							fin        = 1'b1;
							slot_we    = 1'b1;
							slot_wdata = {rd_ts, rd_op, cmd_q.abort_flag, {CW{1'b0}}};
						end
						default: begin
							state_d = ST_W_POP;
							q_we    = 1'b1;
							q_waddr = '0;
							q_wdata = s_idx;
						end
					endcase
				end
			end
			ST_R_RD: begin
				if (idx_q == n_q) begin
					fin     = 1'b1;
					fin_st  = STAT_REJ;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_R_CMP;
				end
			end
			ST_R_CMP: begin
				if (list_rdata.slot == cmd_q.waiter_slot && list_rdata.ts == cmd_q.waiter_ts
						&& list_rdata.op == cmd_q.waiter_op) begin
					state_d = ST_S_RD;
				end else begin
					state_d = ST_R_RD;
				end
			end
			ST_S_RD: begin
				list_raddr = laddr(s_idx, idx_nx);
				if (idx_nx < n_q) begin
					state_d = ST_S_WR;
				end else begin
					slot_we = 1'b1;
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_S_WR: begin
				list_we = 1'b1;
				state_d = ST_S_RD;
			end
			ST_W_POP: begin
				if (rdp_q == wrp_q) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_W_CUR0;
				end
			end
			ST_W_CUR0: begin
				slot_raddr = q_rdata;
				state_d    = vis_q[q_rdata] ? ST_W_POP : ST_W_CUR1;
			end
			ST_W_CUR1: begin
				state_d = ST_W_ERD;
			end
			ST_W_ERD: begin
				list_raddr = laddr(cur_q, idx_q);
				state_d    = (idx_q == n_q) ? ST_W_POP : ST_W_ESL;
			end
			ST_W_ESL: begin
				slot_raddr = AW'(list_rdata.slot);
				state_d    = w_ok ? ST_W_ECHK : ST_W_ERD;
			end
			ST_W_ECHK: begin
				state_d = ST_W_ERD;
				if (rd_ts != '0 && rd_ts == wts_q) begin
					if (w_q == s_idx) begin
						fin     = 1'b1;
						fin_dl  = 1'b1;
						state_d = ST_IDLE;
					end else if (!add_q[w_q] && wrp_q < QCAP) begin
						q_we = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			svld_q     <= '0;
			srd_vld_q  <= 1'b0;
			grp_open_q <= 1'b0;
			grp_acc_q  <= 1'b0;
			done_q     <= 1'b0;
			vis_q      <= '0;
			add_q      <= '0;
			rdp_q      <= '0;
			wrp_q      <= '0;
		end else begin
			srd_vld_q <= svld_q[slot_raddr];
			if (slot_we) begin
				svld_q[slot_waddr] <= 1'b1;
			end
			done_q <= fin;
			if (state_q == ST_CHK) begin
				if (cmd_q.action == ACT_ADD) begin
					if (!grp_open_q) begin
						grp_acc_q <= s_ok && (newer || same);
					end
					grp_open_q <= !cmd_q.last;
				end else begin
					grp_open_q <= 1'b0;
				end
				vis_q <= '0;
				add_q <= '0;
				rdp_q <= '0;
				wrp_q <= QW'(1);
			end
			if (state_q == ST_W_CUR0) begin
				rdp_q <= rdp_q + QW'(1);
				vis_q[q_rdata] <= 1'b1;
			end
			if (q_we && state_q == ST_W_ECHK) begin
				add_q[w_q] <= 1'b1;
				wrp_q      <= wrp_q + QW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			rsp_q <= '{status: fin_st, deadlock: fin_dl};
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q <= cmd;
				end
			end
			ST_CHK: begin
				e_ts_q <= rd_ts;
				e_op_q <= rd_op;
				e_ab_q <= rd_ab;
				n_q    <= rd_cnt;
				idx_q  <= '0;
			end
			ST_R_CMP: begin
				if (!(list_rdata.slot == cmd_q.waiter_slot && list_rdata.ts == cmd_q.waiter_ts
						&& list_rdata.op == cmd_q.waiter_op)) begin
					idx_q <= idx_nx;
				end
			end
			ST_S_WR: begin
				idx_q <= idx_nx;
			end
			ST_W_CUR0: begin
				cur_q <= q_rdata;
			end
			ST_W_CUR1: begin
				n_q   <= rd_cnt;
				idx_q <= '0;
			end
			ST_W_ESL: begin
				w_q   <= AW'(list_rdata.slot);
				wts_q <= list_rdata.ts;
				if (!w_ok) begin
					idx_q <= idx_nx;
				end
			end
			ST_W_ECHK: begin
				idx_q <= idx_nx;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/wait_for_graph_deadlock_detector.sv =====
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector
// Wait-for graph per transaction slot with add, remove, clear and cycle check.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on rsp for one cycle with done high, and the receiver cannot stall.
// Add and clear finish in the check state. Remove scans the waiters of the slot
// and then shifts the entries after the match down. Detect walks each slot
// reached, skips repeated visits and reads every waiter on those lists, and
// stops early when the walk closes a cycle. All of it is bound by the one
// read port of the slot table and of the waiter list memory, which every
// step goes through.
module wait_for_graph_deadlock_detector #(
	parameter int SLOTS            = 32,
	parameter int WAITERS_PER_SLOT = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  wfg_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output wfg_pkg::rsp_t rsp
);
	import wfg_pkg::*;

	localparam int AW  = $clog2(SLOTS);
	localparam int SEW = 96 + $clog2(WAITERS_PER_SLOT + 1);
	localparam int LAW = $clog2(SLOTS * WAITERS_PER_SLOT);

	logic           slot_we;
	logic [AW-1:0]  slot_waddr, slot_raddr;
	logic [SEW-1:0] slot_wdata, slot_rdata;
	logic           list_we;
	logic [LAW-1:0] list_waddr, list_raddr;
	waiter_t        list_wdata, list_rdata;

	wfg_ctrl #(.SLOTS(SLOTS), .WAITERS_PER_SLOT(WAITERS_PER_SLOT)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.rsp        (rsp),
		.slot_we    (slot_we),
		.slot_waddr (slot_waddr),
		.slot_wdata (slot_wdata),
		.slot_raddr (slot_raddr),
		.slot_rdata (slot_rdata),
		.list_we    (list_we),
		.list_waddr (list_waddr),
		.list_wdata (list_wdata),
		.list_raddr (list_raddr),
		.list_rdata (list_rdata)
	);

	wfg_ram #(.WIDTH(SEW), .DEPTH(SLOTS)) u_slot_mem (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	wfg_ram #(.WIDTH($bits(waiter_t)), .DEPTH(SLOTS * WAITERS_PER_SLOT)) u_list_mem (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

endmodule

// ===== rtl/core/wfg_checker.sv =====
// ----------------------------------------------------------------------------
// wfg_checker
// Port-level checks on the detector, attached by bind.
// ----------------------------------------------------------------------------
module wfg_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input wfg_pkg::rsp_t rsp
);
	import wfg_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == STAT_OK || rsp.status == STAT_REJ || rsp.status == STAT_FULL))
		else $error("bad status code");

	a_deadlock_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.deadlock |-> rsp.status == STAT_OK)
		else $error("deadlock with non-ok status");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("beat taken without going busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe out of sequence");

endmodule

bind wait_for_graph_deadlock_detector wfg_checker u_wfg_checker (.*);
